[sv/oarp_pkg.sv]
`timescale 1ns / 1ps

package oarp_pkg;

  // Data bytes carried by one result transfer (fixed by the result format).
  localparam int unsigned DataFields   = 8;
  localparam int unsigned MaxDataBytes = 8;

  // Result payload: status, PID, count and eight data bytes, padded to 80 bits.
  localparam int unsigned ResultBits = 2 + 8 + 4 + 8 * DataFields;
  localparam int unsigned TdataBits  = ((ResultBits + 7) / 8) * 8;

  localparam logic [7:0] ChrFour  = 8'h34;  // '4'
  localparam logic [7:0] ChrOne   = 8'h31;  // '1'
  localparam logic [7:0] ChrSpace = 8'h20;  // ' '
  localparam logic [7:0] ChrPlus  = 8'h2B;  // '+'
  localparam logic [7:0] ChrMinus = 8'h2D;  // '-'

  typedef enum logic [3:0] {
    PH_SEARCH   = 4'd0,
    PH_SAW4     = 4'd1,
    PH_AFTER41  = 4'd2,
    PH_PID0     = 4'd3,
    PH_PID1     = 4'd4,
    PH_OPTSPACE = 4'd5,
    PH_DATA_HI  = 4'd6,
    PH_DATA_LO  = 4'd7,
    PH_DONE     = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [DataFields-1:0][7:0] data;   // data[0] in the lowest bits
    logic [3:0]                 count;
    logic [7:0]                 pid;
    status_e                    status;
  } result_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c inside {ChrSpace, [8'h09:8'h0D]});
  endfunction

  // Two-character base-16 conversion with one optional leading blank or sign.
  function automatic logic [7:0] pid_from_chars(input logic [7:0] c0,
                                                input logic [7:0] c1);
    logic [7:0] v;
    v = 8'd0;
    if (is_hex(c0)) begin
      v = is_hex(c1) ? {hex_val(c0), hex_val(c1)} : {4'd0, hex_val(c0)};
    end else if (is_ws(c0) || c0 == ChrPlus) begin
      v = is_hex(c1) ? {4'd0, hex_val(c1)} : 8'd0;
    end else if (c0 == ChrMinus) begin
      v = is_hex(c1) ? 8'(8'd0 - {4'd0, hex_val(c1)}) : 8'd0;
    end
    return v;
  endfunction

endpackage

[sv/oarp_parser.sv]
`timescale 1ns / 1ps

module oarp_parser #(
  parameter int unsigned MAX_DATA_BYTES = oarp_pkg::MaxDataBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        char_i,
  input  logic              last_i,
  output oarp_pkg::result_t result_o
);

  oarp_pkg::phase_e phase_q, phase_d;
  logic [2:0] chars_seen_q, chars_seen_d;
  logic [7:0] first_pid_q, first_pid_d;
  logic [7:0] pid_q, pid_d;
  logic [3:0] high_nib_q, high_nib_d;
  logic [3:0] byte_count_q, byte_count_d;
  logic [7:0] byte_q [MAX_DATA_BYTES];
  logic [7:0] byte_d [MAX_DATA_BYTES];
  logic       byte_wr;
  logic [7:0] byte_wr_val;
  logic       hex_c;
  logic [3:0] val_c;
  logic       room;

  assign hex_c = oarp_pkg::is_hex(char_i);
  assign val_c = oarp_pkg::hex_val(char_i);
  assign room  = (byte_count_q < 4'(MAX_DATA_BYTES));
  assign chars_seen_d = (chars_seen_q < 3'd4) ? 3'(chars_seen_q + 3'd1) : chars_seen_q;

  always_comb begin
    phase_d      = phase_q;
    first_pid_d  = first_pid_q;
    pid_d        = pid_q;
    high_nib_d   = high_nib_q;
    byte_count_d = byte_count_q;
    byte_wr      = 1'b0;
    byte_wr_val  = {high_nib_q, val_c};
    case (phase_q)
      oarp_pkg::PH_SEARCH: begin
        if (char_i == oarp_pkg::ChrFour) phase_d = oarp_pkg::PH_SAW4;
      end
      oarp_pkg::PH_SAW4: begin
        if (char_i == oarp_pkg::ChrOne) begin
          phase_d = oarp_pkg::PH_AFTER41;
        end else if (char_i != oarp_pkg::ChrFour) begin
          phase_d = oarp_pkg::PH_SEARCH;
        end
      end
      oarp_pkg::PH_AFTER41: begin
        if (char_i == oarp_pkg::ChrSpace) begin
          phase_d = oarp_pkg::PH_PID0;
        end else begin
          first_pid_d = char_i;
          phase_d     = oarp_pkg::PH_PID1;
        end
      end
      oarp_pkg::PH_PID0: begin
        first_pid_d = char_i;
        phase_d     = oarp_pkg::PH_PID1;
      end
      oarp_pkg::PH_PID1: begin
        pid_d   = oarp_pkg::pid_from_chars(first_pid_q, char_i);
        phase_d = oarp_pkg::PH_OPTSPACE;
      end
      oarp_pkg::PH_OPTSPACE, oarp_pkg::PH_DATA_HI: begin
        if (phase_q == oarp_pkg::PH_OPTSPACE && char_i == oarp_pkg::ChrSpace) begin
          phase_d = oarp_pkg::PH_DATA_HI;
        end else if (!room || !hex_c) begin
          phase_d = oarp_pkg::PH_DONE;
        end else begin
          high_nib_d = val_c;
          phase_d    = oarp_pkg::PH_DATA_LO;
        end
      end
      oarp_pkg::PH_DATA_LO: begin
        // Room was checked on the high digit.
        if (hex_c) begin
          byte_wr      = 1'b1;
          byte_count_d = 4'(byte_count_q + 4'd1);
          phase_d      = oarp_pkg::PH_OPTSPACE;
        end else begin
          phase_d = oarp_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    byte_d = byte_q;
    if (byte_wr) begin
      for (int k = 0; k < MAX_DATA_BYTES; k++) begin
        if (byte_count_q == 4'(k)) byte_d[k] = byte_wr_val;
      end
    end
  end

  // Result as seen after this character; only used on the last one.
  always_comb begin
    result_o = '0;
    if (chars_seen_d < 3'd4) begin
      result_o.status = oarp_pkg::ST_SHORT;
    end else if (phase_d < oarp_pkg::PH_OPTSPACE) begin
      result_o.status = oarp_pkg::ST_NOT_FOUND;
    end else begin
      result_o.status = oarp_pkg::ST_OK;
      result_o.pid    = pid_d;
      result_o.count  = byte_count_d;
      for (int k = 0; k < MAX_DATA_BYTES; k++) begin
        if (4'(k) < byte_count_d) result_o.data[k] = byte_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= oarp_pkg::PH_SEARCH;
      chars_seen_q <= 3'd0;
      first_pid_q  <= 8'd0;
      pid_q        <= 8'd0;
      high_nib_q   <= 4'd0;
      byte_count_q <= 4'd0;
    end else if (accept_i) begin
      if (last_i) begin
        phase_q      <= oarp_pkg::PH_SEARCH;
        chars_seen_q <= 3'd0;
        first_pid_q  <= 8'd0;
        pid_q        <= 8'd0;
        high_nib_q   <= 4'd0;
        byte_count_q <= 4'd0;
      end else begin
        phase_q      <= phase_d;
        chars_seen_q <= chars_seen_d;
        first_pid_q  <= first_pid_d;
        pid_q        <= pid_d;
        high_nib_q   <= high_nib_d;
        byte_count_q <= byte_count_d;
      end
    end
  end

  // Byte store is masked by the count, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept_i) byte_q <= byte_d;
  end

endmodule

[sv/obd_ascii_response_parser_core.sv]
`timescale 1ns / 1ps

// OBD-II mode 01 ASCII response parser. Feed the response text one character
// per transfer on the slave stream, with tlast on the final character. The
// parser finds the first "41" followed by at least one more character, reads
// two characters as the PID (one leading blank or sign allowed, stops at a
// non-hex character), then up to MAX_DATA_BYTES hex pairs separated by
// optional single spaces. One result transfer leaves per response, registered
// as its last character is taken: status (0 ok, 1 fewer than four
// characters, 2 no marker or PID cut off), PID, byte count and data bytes, with
// every field not meaningful for that status driven to zero. Each character
// passes through a single state update of the parser, and the result register
// loads from the parser's view of the last character, so a character can be
// taken every cycle; the input stalls only while a result sits in the output
// register and the sink holds tready low.
module obd_ascii_response_parser_core #(
  parameter int unsigned MAX_DATA_BYTES = oarp_pkg::MaxDataBytes
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] char_in
  input  logic                           s_axis_tlast_i,  // last_char
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] status, [9:2] pid_value, [13:10] data_count,
  // [21:14] data_0 ... [77:70] data_7, [79:78] zero
  output logic [oarp_pkg::TdataBits-1:0] m_axis_tdata_o
);

  logic              in_xfer;
  oarp_pkg::result_t result;
  oarp_pkg::result_t out_q;
  logic              out_valid_q;

  // Take a character whenever the result register is free or draining.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  oarp_parser #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_xfer),
    .char_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .result_o(result)
  );

  // Result register: load on the last character, drop once transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && s_axis_tlast_i) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tlast_i) out_q <= result;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(oarp_pkg::TdataBits - oarp_pkg::ResultBits)'(0), out_q};

endmodule
